// ----- hdl/slot_table_round_robin_picker_core_defines.svh -----
// Assertion macros for the slot table picker.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef SLOT_TABLE_ROUND_ROBIN_PICKER_CORE_DEFINES_SVH
`define SLOT_TABLE_ROUND_ROBIN_PICKER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define STP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("slot table picker check failed");
`define STP_ASSERT_NR(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("slot table picker reset check failed");
`else
`define STP_ASSERT(name, prop)
`define STP_ASSERT_NR(name, prop)
`endif

`endif

// ----- hdl/stpick_pkg.sv -----
// Shared types and constants for the slot table picker.
// No dependencies; used by stpick_cell and the top level.
package stpick_pkg;

  localparam int OP_BITS  = 3;
  localparam int CFG_BITS = 5;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD       = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_START_ALL = 3'd2,
    OP_GET_NEXT  = 3'd3,
    OP_CLEAR_REQ = 3'd4
  } op_e;

  typedef struct packed {
    logic en;
    op_e  op;
    logic add_ok;
  } cmd_t;

  typedef struct packed {
    logic free_found;
    logic match_found;
    logic hi_found;
    logic lo_found;
  } chain_t;

endpackage

// ----- hdl/stpick_cell.sv -----
// One slot of the table: node id, occupied and request flags.
// Passes first-hit flags and grant candidates to the next cell; uses stpick_pkg.
module stpick_cell #(
  parameter int IDX          = 0,
  parameter int NB           = 5,
  parameter int IB           = 4,
  parameter int NODE_ID_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  stpick_pkg::cmd_t          cmd_i,
  input  logic [NODE_ID_BITS-1:0]   id_i,
  input  logic [NB-1:0]             n_i,
  input  logic [NB-1:0]             scan_base_i,
  input  stpick_pkg::chain_t        chain_i,
  output stpick_pkg::chain_t        chain_o,
  input  logic [NODE_ID_BITS-1:0]   hi_node_i,
  output logic [NODE_ID_BITS-1:0]   hi_node_o,
  input  logic [NODE_ID_BITS-1:0]   lo_node_i,
  output logic [NODE_ID_BITS-1:0]   lo_node_o,
  input  logic [IB-1:0]             hi_slot_i,
  output logic [IB-1:0]             hi_slot_o,
  input  logic [IB-1:0]             lo_slot_i,
  output logic [IB-1:0]             lo_slot_o,
  output logic                      occ_o
);
  import stpick_pkg::*;

  logic [NODE_ID_BITS-1:0] node_q;
  logic                    occ_q;
  logic                    req_q;
  logic                    in_rng;
  logic                    free_hit;
  logic                    match_hit;
  logic                    rq_hit;
  logic                    hi_hit;
  logic                    free_take;
  logic                    match_take;
  logic                    hi_take;
  logic                    lo_take;

  always_comb begin
    in_rng     = NB'(IDX) < n_i;
    free_hit   = in_rng && !occ_q;
    match_hit  = in_rng && occ_q && (node_q == id_i);
    rq_hit     = in_rng && occ_q && req_q;
    hi_hit     = rq_hit && (NB'(IDX) >= scan_base_i);
    free_take  = free_hit && !chain_i.free_found;
    match_take = match_hit && !chain_i.match_found;
    hi_take    = hi_hit && !chain_i.hi_found;
    lo_take    = rq_hit && !chain_i.lo_found;

    chain_o.free_found  = chain_i.free_found | free_hit;
    chain_o.match_found = chain_i.match_found | match_hit;
    chain_o.hi_found    = chain_i.hi_found | hi_hit;
    chain_o.lo_found    = chain_i.lo_found | rq_hit;

    hi_node_o = hi_node_i | (hi_take ? node_q : '0);
    lo_node_o = lo_node_i | (lo_take ? node_q : '0);
    hi_slot_o = hi_slot_i | (hi_take ? IB'(IDX) : '0);
    lo_slot_o = lo_slot_i | (lo_take ? IB'(IDX) : '0);
  end

  assign occ_o = occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      req_q <= 1'b0;
    end else if (cmd_i.en) begin
      case (cmd_i.op)
        OP_ADD: begin
          if (cmd_i.add_ok && free_take) begin
            occ_q <= 1'b1;
            req_q <= 1'b0;
          end
        end
        OP_REMOVE: begin
          if (match_take) begin
            occ_q <= 1'b0;
            req_q <= 1'b0;
          end
        end
        OP_START_ALL: begin
          if (in_rng && occ_q) begin
            req_q <= 1'b1;
          end
        end
        OP_CLEAR_REQ: begin
          if (match_take) begin
            req_q <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.en && (cmd_i.op == OP_ADD) && cmd_i.add_ok && free_take) begin
      node_q <= id_i;
    end
  end

endmodule

// ----- hdl/slot_table_round_robin_picker_core.sv -----
// Slot table with a round-robin picker, built as a row of slot cells.
// Command channel: an operation and node id transfer at a clock edge with
// start high and busy low. Busy then stays high while the cell row
// evaluates the command and updates the table.
// Result channel: one result per command, shown for exactly one cycle with
// result_strobe_o high; the strobe is registered from busy, which is itself
// registered at the command transfer. The receiver cannot stall.
// No new command is taken while busy is high: the registered command stage
// is followed by the evaluate-and-update step of the cell row.
// Configuration: slot_count is written through cfg_valid_i / cfg_ready_o
// while idle; cfg_ready_o is low while a command is in progress.
// Reset (rst_ni low, asynchronous) empties every slot, clears all request
// flags, forgets the last grant and sets slot_count to 16. Node ids of
// empty slots hold no defined value.
// Depends on stpick_pkg, stpick_cell and the assertion macro header.
`include "slot_table_round_robin_picker_core_defines.svh"

module slot_table_round_robin_picker_core #(
  parameter int SLOTS        = 16,
  parameter int NODE_ID_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [stpick_pkg::OP_BITS-1:0]  operation_i,
  input  logic [NODE_ID_BITS-1:0]         node_id_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [stpick_pkg::CFG_BITS-1:0] cfg_data_i,
  output logic                            result_strobe_o,
  output logic                            grant_valid_o,
  output logic [$clog2(SLOTS)-1:0]        grant_slot_o,
  output logic [NODE_ID_BITS-1:0]         grant_node_o,
  output logic                            op_done_o,
  output logic                            slot_free_o
);
  import stpick_pkg::*;

  localparam int IB = $clog2(SLOTS);
  localparam int NB = $clog2(SLOTS + 1);

  logic                    busy_q;
  logic [OP_BITS-1:0]      op_q;
  logic [NODE_ID_BITS-1:0] id_q;
  logic [CFG_BITS-1:0]     slot_count_q;
  logic [NB-1:0]           used_q;
  logic [NB-1:0]           used_d;
  logic                    lg_vld_q;
  logic [IB-1:0]           lg_q;
  logic                    strobe_q;
  logic                    gvalid_q;
  logic [IB-1:0]           gslot_q;
  logic [NODE_ID_BITS-1:0] gnode_q;
  logic                    done_q;
  logic                    free_q;

  logic [NB-1:0]           n;
  logic [NB-1:0]           lg_next;
  logic [NB-1:0]           scan_base;
  cmd_t                    cmd;
  logic                    grant;
  logic [IB-1:0]           gslot;
  logic [NODE_ID_BITS-1:0] gnode;
  logic                    done;

  chain_t                  chain   [SLOTS+1];
  logic [NODE_ID_BITS-1:0] hi_node [SLOTS+1];
  logic [NODE_ID_BITS-1:0] lo_node [SLOTS+1];
  logic [IB-1:0]           hi_slot [SLOTS+1];
  logic [IB-1:0]           lo_slot [SLOTS+1];
  logic [SLOTS-1:0]        occ_vec;

  assign busy        = busy_q;
  assign cfg_ready_o = !busy_q;

  always_comb begin
    if (32'(slot_count_q) > SLOTS) begin
      n = NB'(SLOTS);
    end else begin
      n = NB'(slot_count_q);
    end
    lg_next = NB'(lg_q) + NB'(1);
    if (!lg_vld_q || (NB'(lg_q) >= n) || (lg_next >= n)) begin
      scan_base = '0;
    end else begin
      scan_base = lg_next;
    end
    cmd.en     = busy_q;
    cmd.op     = op_e'(op_q);
    cmd.add_ok = used_q < n;
  end

  assign chain[0]   = '0;
  assign hi_node[0] = '0;
  assign lo_node[0] = '0;
  assign hi_slot[0] = '0;
  assign lo_slot[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    stpick_cell #(
      .IDX          (g),
      .NB           (NB),
      .IB           (IB),
      .NODE_ID_BITS (NODE_ID_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .id_i        (id_q),
      .n_i         (n),
      .scan_base_i (scan_base),
      .chain_i     (chain[g]),
      .chain_o     (chain[g+1]),
      .hi_node_i   (hi_node[g]),
      .hi_node_o   (hi_node[g+1]),
      .lo_node_i   (lo_node[g]),
      .lo_node_o   (lo_node[g+1]),
      .hi_slot_i   (hi_slot[g]),
      .hi_slot_o   (hi_slot[g+1]),
      .lo_slot_i   (lo_slot[g]),
      .lo_slot_o   (lo_slot[g+1]),
      .occ_o       (occ_vec[g])
    );
  end

  always_comb begin
    grant  = 1'b0;
    gslot  = '0;
    gnode  = '0;
    done   = 1'b0;
    used_d = used_q;
    case (op_q)
      OP_ADD: begin
        done = cmd.add_ok && chain[SLOTS].free_found;
        if (done) begin
          used_d = used_q + NB'(1);
        end
      end
      OP_REMOVE: begin
        done = chain[SLOTS].match_found;
        if (done && (used_q != '0)) begin
          used_d = used_q - NB'(1);
        end
      end
      OP_GET_NEXT: begin
        grant = chain[SLOTS].hi_found || chain[SLOTS].lo_found;
        if (chain[SLOTS].hi_found) begin
          gslot = hi_slot[SLOTS];
          gnode = hi_node[SLOTS];
        end else begin
          gslot = lo_slot[SLOTS];
          gnode = lo_node[SLOTS];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      strobe_q     <= 1'b0;
      slot_count_q <= CFG_RESET;
      used_q       <= '0;
      lg_vld_q     <= 1'b0;
      lg_q         <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        slot_count_q <= cfg_data_i;
      end
      if (start && !busy_q) begin
        busy_q <= 1'b1;
      end else begin
        busy_q <= 1'b0;
      end
      strobe_q <= busy_q;
      if (busy_q) begin
        used_q <= used_d;
        if (grant) begin
          lg_vld_q <= 1'b1;
          lg_q     <= gslot;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy_q) begin
      op_q <= operation_i;
      id_q <= node_id_i;
    end
    if (busy_q) begin
      gvalid_q <= grant;
      gslot_q  <= gslot;
      gnode_q  <= gnode;
      done_q   <= done;
      free_q   <= used_d < n;
    end
  end

  assign result_strobe_o = strobe_q;
  assign grant_valid_o   = gvalid_q;
  assign grant_slot_o    = gslot_q;
  assign grant_node_o    = gnode_q;
  assign op_done_o       = done_q;
  assign slot_free_o     = free_q;

  `STP_ASSERT(a_result_follows_cmd, busy |=> result_strobe_o && !busy)
  `STP_ASSERT(a_grant_moves_pointer,
              (result_strobe_o && grant_valid_o) |-> (lg_vld_q && (lg_q == grant_slot_o)))
  `STP_ASSERT(a_used_matches_occ, used_q == NB'($countones(occ_vec)))
  `STP_ASSERT_NR(a_reset_quiet, !rst_ni |=> (!busy && !result_strobe_o))

endmodule

// ----- test/slot_table_round_robin_picker_core_tb.sv -----
// Testbench for slot_table_round_robin_picker_core: directed and random commands
// against a scoreboard that tracks the slot table and round-robin pointer.
// Depends on stpick_pkg and the core RTL only.
`timescale 1ns / 100ps

module testbench;
  import stpick_pkg::*;

  localparam int SLOTS        = 16;
  localparam int ID_BITS      = 8;
  localparam int SLOT_BITS    = 4;
  localparam int POOL_SIZE    = 6;
  localparam int CYCLE_LIMIT  = 100000;
  localparam logic [OP_BITS-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_BITS-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_BITS-1:0] OP_SPARE_C = 3'd7;

  typedef struct packed {
    logic                 grant_valid;
    logic [SLOT_BITS-1:0] grant_slot;
    logic [ID_BITS-1:0]   grant_node;
    logic                 op_done;
    logic                 slot_free;
  } grant_reply_t;

  class slot_table_scoreboard;
    logic [ID_BITS-1:0] node_of [SLOTS];
    bit                 occupied [SLOTS];
    bit                 requested [SLOTS];
    int                 used_count;
    int                 last_grant;
    int                 slot_count;
    grant_reply_t       awaited_replies[$];
    int                 mismatches;
    int                 grants_seen;
    int                 commands_seen;

    function new();
      int i;
      for (i = 0; i < SLOTS; i++) begin
        node_of[i]   = '0;
        occupied[i]  = 1'b0;
        requested[i] = 1'b0;
      end
      used_count    = 0;
      last_grant    = -1;
      slot_count    = 16;
      mismatches    = 0;
      grants_seen   = 0;
      commands_seen = 0;
    endfunction

    function logic [ID_BITS-1:0] held_id(logic [ID_BITS-1:0] fallback);
      int picks[$];
      int i;
      for (i = 0; i < SLOTS; i++) if (occupied[i]) picks.push_back(i);
      if (picks.size() == 0 || $urandom_range(4) == 0) return fallback;
      return node_of[picks[$urandom_range(picks.size() - 1)]];
    endfunction

    function void note_command(logic [OP_BITS-1:0] op, logic [ID_BITS-1:0] id);
      grant_reply_t r;
      int n, k, i, pos;
      n = (slot_count > SLOTS) ? SLOTS : slot_count;
      r = '0;
      k = n;
      for (i = n - 1; i >= 0; i--) if (occupied[i] && node_of[i] == id) k = i;
      case (op)
        OP_ADD: begin
          if (used_count < n) begin
            for (i = 0; i < n; i++) begin
              if (!occupied[i]) begin
                node_of[i]   = id;
                occupied[i]  = 1'b1;
                requested[i] = 1'b0;
                used_count++;
                r.op_done = 1'b1;
                break;
              end
            end
          end
        end
        OP_REMOVE: begin
          if (k < n) begin
            occupied[k]  = 1'b0;
            requested[k] = 1'b0;
            if (used_count > 0) used_count--;
            r.op_done = 1'b1;
          end
        end
        OP_START_ALL: begin
          for (i = 0; i < n; i++) if (occupied[i]) requested[i] = 1'b1;
        end
        OP_GET_NEXT: begin
          if (n > 0) begin
            pos = (last_grant < 0 || last_grant >= n) ? 0 : last_grant + 1;
            if (pos >= n) pos = 0;
            for (i = 0; i < n; i++) begin
              if (occupied[pos] && requested[pos]) begin
                last_grant    = pos;
                r.grant_valid = 1'b1;
                r.grant_slot  = SLOT_BITS'(pos);
                r.grant_node  = node_of[pos];
                break;
              end
              pos = (pos + 1 >= n) ? 0 : pos + 1;
            end
          end
        end
        OP_CLEAR_REQ: begin
          if (k < n) requested[k] = 1'b0;
        end
        default: begin
        end
      endcase
      r.slot_free = (used_count < n);
      commands_seen++;
      awaited_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply(grant_reply_t got);
      grant_reply_t want;
      if (awaited_replies.size() == 0) begin
        $error("result strobe with no command pending");
        mismatches++;
        return;
      end
      want = awaited_replies.pop_front();
      if (got.grant_valid === 1'b1) grants_seen++;
      compare_field("grant_valid", 32'(want.grant_valid), 32'(got.grant_valid));
      compare_field("grant_slot", 32'(want.grant_slot), 32'(got.grant_slot));
      compare_field("grant_node", 32'(want.grant_node), 32'(got.grant_node));
      compare_field("op_done", 32'(want.op_done), 32'(got.op_done));
      compare_field("slot_free", 32'(want.slot_free), 32'(got.slot_free));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni       = 1'b0;
  logic                 start        = 1'b0;
  logic                 busy;
  logic [OP_BITS-1:0]   operation_i  = '0;
  logic [ID_BITS-1:0]   node_id_i    = '0;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_BITS-1:0]  cfg_data_i   = '0;
  logic                 result_strobe_o;
  logic                 grant_valid_o;
  logic [SLOT_BITS-1:0] grant_slot_o;
  logic [ID_BITS-1:0]   grant_node_o;
  logic                 op_done_o;
  logic                 slot_free_o;

  slot_table_scoreboard tracker;
  logic [ID_BITS-1:0]   id_pool [POOL_SIZE];
  int                   idle_pct;
  int                   cfg_writes;
  int                   cycle_count;

  slot_table_round_robin_picker_core #(
    .SLOTS       (SLOTS),
    .NODE_ID_BITS(ID_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .node_id_i      (node_id_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_strobe_o(result_strobe_o),
    .grant_valid_o  (grant_valid_o),
    .grant_slot_o   (grant_slot_o),
    .grant_node_o   (grant_node_o),
    .op_done_o      (op_done_o),
    .slot_free_o    (slot_free_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o === 1'b1)
      tracker.check_reply({grant_valid_o, grant_slot_o, grant_node_o, op_done_o, slot_free_o});
  end

  task automatic send_command(input logic [OP_BITS-1:0] op, input logic [ID_BITS-1:0] id);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start       <= 1'b1;
    operation_i <= op;
    node_id_i   <= id;
    do @(posedge clk_i); while (busy !== 1'b0);
    tracker.note_command(op, id);
  endtask

  // hold start low until every pending result has been checked
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (tracker.awaited_replies.size() > 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_slot_count(input logic [CFG_BITS-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    tracker.slot_count = int'(value);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_command();
    int r;
    logic [ID_BITS-1:0] id;
    if ($urandom_range(39) == 0) drain();
    r  = $urandom_range(99);
    id = ($urandom_range(3) == 0) ? ID_BITS'($urandom) : id_pool[$urandom_range(POOL_SIZE - 1)];
    if (r < 25)      send_command(OP_ADD, id);
    else if (r < 43) send_command(OP_REMOVE, tracker.held_id(id));
    else if (r < 53) send_command(OP_START_ALL, id);
    else if (r < 85) send_command(OP_GET_NEXT, id);
    else if (r < 95) send_command(OP_CLEAR_REQ, tracker.held_id(id));
    else             send_command(OP_BITS'($urandom_range(OP_SPARE_A, OP_SPARE_C)), id);
  endtask

  initial begin
    int seg, i, r, value;
    tracker     = new();
    idle_pct    = 0;
    cfg_writes  = 0;
    cycle_count = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_command(OP_GET_NEXT, 8'h00);
    send_command(OP_REMOVE, 8'hAA);
    send_command(OP_CLEAR_REQ, 8'hAA);
    send_command(OP_ADD, 8'h00);
    send_command(OP_ADD, 8'hFF);
    send_command(OP_ADD, 8'h5A);
    send_command(OP_ADD, 8'h5A);
    send_command(OP_GET_NEXT, 8'h00);
    send_command(OP_START_ALL, 8'h00);
    repeat (5) send_command(OP_GET_NEXT, 8'h00);
    send_command(OP_CLEAR_REQ, 8'h5A);
    send_command(OP_GET_NEXT, 8'h00);
    send_command(OP_REMOVE, 8'hFF);
    send_command(OP_GET_NEXT, 8'h00);
    send_command(OP_SPARE_A, 8'hFF);
    send_command(OP_SPARE_B, 8'h00);
    send_command(OP_SPARE_C, 8'hFF);

    write_slot_count(5'd3);
    send_command(OP_ADD, 8'h11);
    send_command(OP_GET_NEXT, 8'h00);
    send_command(OP_REMOVE, 8'h5A);
    send_command(OP_ADD, 8'h22);
    write_slot_count(5'd0);
    send_command(OP_ADD, 8'h33);
    send_command(OP_START_ALL, 8'h00);
    send_command(OP_GET_NEXT, 8'h00);
    write_slot_count(5'd1);
    send_command(OP_GET_NEXT, 8'h00);
    write_slot_count(5'd31);
    send_command(OP_GET_NEXT, 8'h00);

    for (seg = 0; seg < 9; seg++) begin
      idle_pct = (seg < 3) ? 27 : (seg < 6) ? 56 : 0;
      r = $urandom_range(99);
      value = (seg == 0) ? 16 : (r < 15) ? $urandom_range(17, 31) :
              (r < 25) ? 1 : $urandom_range(2, 16);
      write_slot_count(CFG_BITS'(value));
      for (i = 0; i < POOL_SIZE; i++) id_pool[i] = ID_BITS'($urandom);
      repeat (78) random_command();
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (tracker.awaited_replies.size() > 0) begin
      $error("%0d results never arrived", tracker.awaited_replies.size());
      tracker.mismatches++;
    end
    $display("Covered %0d commands over %0d slot count writes, including 0, 1, 3 and 31.",
             tracker.commands_seen, cfg_writes);
    $display("Observed %0d grants with sender idling at 27, 56 and 0 percent.",
             tracker.grants_seen);
    if (tracker.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
